// ===== rtl/core/seps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seps_pkg
// Shared types, command codes and beat builders for the SPI EEPROM page
// sequencer.
// ----------------------------------------------------------------------------
package seps_pkg;

	localparam int OPCODE_W  = 3;
	localparam int START_W   = 14;
	localparam int BYTE_W    = 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_BEGIN_WRITE  = 3'd0,
		OP_WRITE_DATA   = 3'd1,
		OP_BEGIN_READ   = 3'd2,
		OP_READ_NEXT    = 3'd3,
		OP_STATUS_REPLY = 3'd4,
		OP_READ_REPLY   = 3'd5
	} opcode_t;

	localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;
	localparam logic [BYTE_W-1:0] CMD_RDSR  = 8'h05;
	localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_WRDI  = 8'h04;
	localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;
	localparam logic [BYTE_W-1:0] DUMMY     = 8'h00;

	localparam int SR_WIP_BIT = 0;
	localparam int SR_WEL_BIT = 1;

	typedef struct packed {
		logic [BYTE_W-1:0] spi_out_byte;
		logic              send_valid;
		logic              deselect_after;
		logic [BYTE_W-1:0] read_value;
		logic              read_valid;
		logic              op_done;
	} beat_t;

	function automatic beat_t send_beat(input logic [BYTE_W-1:0] b, input logic desel);
		beat_t r;
		r = '0;
		r.spi_out_byte   = b;
		r.send_valid     = 1'b1;
		r.deselect_after = desel;
		return r;
	endfunction

	function automatic beat_t read_beat(input logic [BYTE_W-1:0] b, input logic last);
		beat_t r;
		r = '0;
		r.read_value = b;
		r.read_valid = 1'b1;
		r.op_done    = last;
		return r;
	endfunction

	function automatic beat_t done_beat();
		beat_t r;
		r = '0;
		r.op_done = 1'b1;
		return r;
	endfunction

endpackage

// ===== rtl/core/seps_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seps_req_if
// Request channel: host requests and EEPROM replies into the sequencer.
// ----------------------------------------------------------------------------
interface seps_req_if;
	logic                         valid;
	logic                         ready;
	logic [seps_pkg::OPCODE_W-1:0] opcode;
	logic [seps_pkg::START_W-1:0]  start_address;
	logic [seps_pkg::BYTE_W-1:0]   data_byte;
	logic                         final_item;

	modport source (output valid, opcode, start_address, data_byte, final_item, input ready);
	modport sink   (input valid, opcode, start_address, data_byte, final_item, output ready);
endinterface

// ===== rtl/core/seps_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seps_rsp_if
// Result channel: SPI bytes, read data and completion marks.
// ----------------------------------------------------------------------------
interface seps_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [seps_pkg::BYTE_W-1:0] spi_out_byte;
	logic                       send_valid;
	logic                       deselect_after;
	logic [seps_pkg::BYTE_W-1:0] read_value;
	logic                       read_valid;
	logic                       op_done;
	logic                       run_end;

	modport source (output valid, spi_out_byte, send_valid, deselect_after, read_value,
		read_valid, op_done, run_end, input ready);
	modport sink   (input valid, spi_out_byte, send_valid, deselect_after, read_value,
		read_valid, op_done, run_end, output ready);
endinterface

// ===== rtl/core/spi_eeprom_page_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_page_sequencer
// Command sequencer for a 25xx-style SPI EEPROM: page writes with enable,
// status polling and page-wrap handling, and streamed reads.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      content
//  req      in   valid/ready    opcode, start_address, data_byte, final_item
//  rsp      out  valid/ready    one SPI byte, read byte or done mark per beat
//
//  a request enters a one-entry input register and is decoded into up to
//  three result beats, held in a three-entry result buffer
//  one result beat leaves per cycle while rsp.ready is high; the next
//  request waits in the input register while the buffer drains
//  after a begin write, the page offset of the new address settles through
//  the pend_s1 (reciprocal multiply) and pend_s2 (correction) steps before
//  the next request runs
//  arst_n clears phase, address, buffer and input register
// ----------------------------------------------------------------------------
module spi_eeprom_page_sequencer #(
	parameter int PAGE_BYTES   = 64,
	parameter int ADDRESS_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	seps_req_if.sink    req,
	seps_rsp_if.source  rsp
);

	localparam int AB     = ADDRESS_BITS;
	localparam int OFF_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
	localparam int RECIP  = (2 ** ADDRESS_BITS) / PAGE_BYTES;
	localparam int BW     = seps_pkg::BYTE_W;

	typedef enum logic [6:0] {
		PH_IDLE       = 7'b0000001,
		PH_WEL_SET    = 7'b0000010,
		PH_WRITE      = 7'b0000100,
		PH_WIP_CLEAR  = 7'b0001000,
		PH_WEL_CLEAR  = 7'b0010000,
		PH_READ_READY = 7'b0100000,
		PH_READ_WAIT  = 7'b1000000
	} phase_t;

	// input register
	logic                          s1_valid_q;
	logic [seps_pkg::OPCODE_W-1:0] s1_opcode_q;
	logic [seps_pkg::START_W-1:0]  s1_start_q;
	logic [BW-1:0]                 s1_data_q;
	logic                          s1_final_q;

	// sequencer state
	phase_t          phase_q, phase_n;
	logic [AB-1:0]   addr_q, addr_n;
	logic [OFF_W-1:0] off_q, off_n;
	logic            finishing_q, finishing_n;

	// result buffer
	seps_pkg::beat_t beat_q [3];
	seps_pkg::beat_t beat_n [3];
	logic [1:0]      cnt_q, cnt_n;
	logic [1:0]      idx_q;

	// page offset recovery
	logic            pend_s1, pend_s2;
	logic [AB-1:0]   quot_s2;
	logic [2*AB-1:0] prod_c;
	logic [AB:0]     rem_full_c, rem_c;

	logic            out_fire, out_last, buf_free, proc, load_off;
	logic [AB-1:0]   ld_addr, addr_inc;
	logic [15:0]     addr16_cur, addr16_ld;
	logic            boundary;

	assign out_fire = rsp.valid && rsp.ready;
	assign out_last = (idx_q == cnt_q - 2'd1);
	assign buf_free = (cnt_q == 2'd0) || (out_fire && out_last);
	assign proc     = s1_valid_q && buf_free && !pend_s1 && !pend_s2;
	assign req.ready = !s1_valid_q || proc;

	assign ld_addr    = AB'(s1_start_q);
	assign addr_inc   = addr_q + AB'(1);
	assign addr16_cur = 16'(addr_q);
	assign addr16_ld  = 16'(ld_addr);

	always_comb begin
		phase_n     = phase_q;
		addr_n      = addr_q;
		off_n       = off_q;
		finishing_n = finishing_q;
		cnt_n       = 2'd0;
		load_off    = 1'b0;
		boundary    = 1'b0;
		for (int i = 0; i < 3; i++) begin
			beat_n[i] = '0;
		end
		unique case (phase_q)
			PH_IDLE: begin
				if (s1_opcode_q == seps_pkg::OP_BEGIN_WRITE) begin
					addr_n      = ld_addr;
					finishing_n = 1'b0;
					load_off    = 1'b1;
					beat_n[0]   = seps_pkg::send_beat(seps_pkg::CMD_WREN, 1'b1);
					beat_n[1]   = seps_pkg::send_beat(seps_pkg::CMD_RDSR, 1'b0);
					beat_n[2]   = seps_pkg::send_beat(seps_pkg::DUMMY, 1'b1);
					cnt_n       = 2'd3;
					phase_n     = PH_WEL_SET;
				end else if (s1_opcode_q == seps_pkg::OP_BEGIN_READ) begin
					addr_n      = ld_addr;
					finishing_n = 1'b0;
					beat_n[0]   = seps_pkg::send_beat(seps_pkg::CMD_READ, 1'b0);
					beat_n[1]   = seps_pkg::send_beat(addr16_ld[15:8], 1'b0);
					beat_n[2]   = seps_pkg::send_beat(addr16_ld[7:0], 1'b0);
					cnt_n       = 2'd3;
					phase_n     = PH_READ_READY;
				end
			end
			PH_WEL_SET: begin
				if (s1_opcode_q == seps_pkg::OP_STATUS_REPLY) begin
					if (!s1_data_q[seps_pkg::SR_WEL_BIT]) begin
						beat_n[0] = seps_pkg::send_beat(seps_pkg::CMD_RDSR, 1'b0);
						beat_n[1] = seps_pkg::send_beat(seps_pkg::DUMMY, 1'b1);
						cnt_n     = 2'd2;
					end else begin
						beat_n[0] = seps_pkg::send_beat(seps_pkg::CMD_WRITE, 1'b0);
						beat_n[1] = seps_pkg::send_beat(addr16_cur[15:8], 1'b0);
						beat_n[2] = seps_pkg::send_beat(addr16_cur[7:0], 1'b0);
						cnt_n     = 2'd3;
						phase_n   = PH_WRITE;
					end
				end
			end
			PH_WRITE: begin
				if (s1_opcode_q == seps_pkg::OP_WRITE_DATA) begin
					addr_n = addr_inc;
					if (addr_inc == '0 || 32'(off_q) == PAGE_BYTES - 1) begin
						off_n = '0;
					end else begin
						off_n = off_q + OFF_W'(1);
					end
					boundary  = (off_n == '0);
					beat_n[0] = seps_pkg::send_beat(s1_data_q, boundary || s1_final_q);
					cnt_n     = 2'd1;
					if (boundary || s1_final_q) begin
						finishing_n = s1_final_q;
						beat_n[1]   = seps_pkg::send_beat(seps_pkg::CMD_RDSR, 1'b0);
						beat_n[2]   = seps_pkg::send_beat(seps_pkg::DUMMY, 1'b1);
						cnt_n       = 2'd3;
						phase_n     = PH_WIP_CLEAR;
					end
				end
			end
			PH_WIP_CLEAR: begin
				if (s1_opcode_q == seps_pkg::OP_STATUS_REPLY) begin
					if (s1_data_q[seps_pkg::SR_WIP_BIT]) begin
						beat_n[0] = seps_pkg::send_beat(seps_pkg::CMD_RDSR, 1'b0);
						beat_n[1] = seps_pkg::send_beat(seps_pkg::DUMMY, 1'b1);
						cnt_n     = 2'd2;
					end else begin
						if (finishing_q) begin
							beat_n[0] = seps_pkg::send_beat(seps_pkg::CMD_WRDI, 1'b1);
							phase_n   = PH_WEL_CLEAR;
						end else begin
							beat_n[0] = seps_pkg::send_beat(seps_pkg::CMD_WREN, 1'b1);
							phase_n   = PH_WEL_SET;
						end
						beat_n[1] = seps_pkg::send_beat(seps_pkg::CMD_RDSR, 1'b0);
						beat_n[2] = seps_pkg::send_beat(seps_pkg::DUMMY, 1'b1);
						cnt_n     = 2'd3;
					end
				end
			end
			PH_WEL_CLEAR: begin
				if (s1_opcode_q == seps_pkg::OP_STATUS_REPLY) begin
					if (s1_data_q[seps_pkg::SR_WEL_BIT]) begin
						beat_n[0] = seps_pkg::send_beat(seps_pkg::CMD_RDSR, 1'b0);
						beat_n[1] = seps_pkg::send_beat(seps_pkg::DUMMY, 1'b1);
						cnt_n     = 2'd2;
					end else begin
						beat_n[0]   = seps_pkg::done_beat();
						cnt_n       = 2'd1;
						finishing_n = 1'b0;
						phase_n     = PH_IDLE;
					end
				end
			end
			PH_READ_READY: begin
				if (s1_opcode_q == seps_pkg::OP_READ_NEXT) begin
					finishing_n = s1_final_q;
					beat_n[0]   = seps_pkg::send_beat(seps_pkg::DUMMY, s1_final_q);
					cnt_n       = 2'd1;
					phase_n     = PH_READ_WAIT;
				end
			end
			PH_READ_WAIT: begin
				if (s1_opcode_q == seps_pkg::OP_READ_REPLY) begin
					beat_n[0]   = seps_pkg::read_beat(s1_data_q, finishing_q);
					cnt_n       = 2'd1;
					addr_n      = addr_inc;
					finishing_n = 1'b0;
					phase_n     = finishing_q ? PH_IDLE : PH_READ_READY;
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			s1_opcode_q <= req.opcode;
			s1_start_q  <= req.start_address;
			s1_data_q   <= req.data_byte;
			s1_final_q  <= req.final_item;
		end
	end

	// state and result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			addr_q      <= '0;
			finishing_q <= 1'b0;
			off_q       <= '0;
			cnt_q       <= 2'd0;
			idx_q       <= 2'd0;
			pend_s1     <= 1'b0;
			pend_s2     <= 1'b0;
		end else begin
			pend_s1 <= proc && load_off;
			pend_s2 <= pend_s1;
			if (proc) begin
				phase_q     <= phase_n;
				addr_q      <= addr_n;
				finishing_q <= finishing_n;
				off_q       <= off_n;
				cnt_q       <= cnt_n;
				idx_q       <= 2'd0;
			end else begin
				if (out_fire) begin
					if (out_last) begin
						cnt_q <= 2'd0;
						idx_q <= 2'd0;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				if (pend_s2) begin
					off_q <= OFF_W'(rem_c);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < 3; i++) begin
				beat_q[i] <= beat_n[i];
			end
		end
	end

	// page offset of a freshly loaded address
	assign prod_c = (2*AB)'(addr_q) * (2*AB)'(RECIP);

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			quot_s2 <= prod_c[2*AB-1:AB];
		end
	end

	assign rem_full_c = (AB+1)'(addr_q) - (AB+1)'(quot_s2 * AB'(PAGE_BYTES));
	assign rem_c      = (32'(rem_full_c) >= PAGE_BYTES) ?
		rem_full_c - (AB+1)'(PAGE_BYTES) : rem_full_c;

	// result port
	assign rsp.valid          = (cnt_q != 2'd0);
	assign rsp.spi_out_byte   = beat_q[idx_q].spi_out_byte;
	assign rsp.send_valid     = beat_q[idx_q].send_valid;
	assign rsp.deselect_after = beat_q[idx_q].deselect_after;
	assign rsp.read_value     = beat_q[idx_q].read_value;
	assign rsp.read_valid     = beat_q[idx_q].read_valid;
	assign rsp.op_done        = beat_q[idx_q].op_done;
	assign rsp.run_end        = out_last;

	// checks
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (idx_q < cnt_q))
		else $error("result index beyond buffered beats");

	a_off_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		(!pend_s1 && !pend_s2) |-> (32'(off_q) < PAGE_BYTES))
		else $error("page offset out of range");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.op_done) |-> rsp.run_end)
		else $error("done beat is not the last of its run");

	a_beat_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.send_valid != rsp.read_valid) || rsp.op_done))
		else $error("beat carries neither or both of send and read data");

endmodule

// ===== verif/spi_eeprom_page_sequencer_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_page_sequencer_check
// Watches the request and result channels of the page sequencer, keeps its
// own copy of the command sequencing state, queues the beats each accepted
// request must produce and compares every result beat against the oldest
// queued one. Hands the mismatch count and the number of beats still owed
// to the testbench top.
// ----------------------------------------------------------------------------
module spi_eeprom_page_sequencer_check #(
	parameter int PAGE_BYTES   = 64,
	parameter int ADDRESS_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	seps_req_if  req,
	seps_rsp_if  rsp,
	output int   fail_count,
	output int   outstanding
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LATCH_SET,
		ST_WRITE_DATA,
		ST_WIP_CLEAR,
		ST_LATCH_CLEAR,
		ST_READ_READY,
		ST_READ_WAIT
	} seq_phase_t;

	typedef struct packed {
		logic [seps_pkg::BYTE_W-1:0] spi_out_byte;
		logic                        send_valid;
		logic                        deselect_after;
		logic [seps_pkg::BYTE_W-1:0] read_value;
		logic                        read_valid;
		logic                        op_done;
		logic                        run_end;
	} sequencer_beat_t;

	seq_phase_t              seq_phase;
	logic [ADDRESS_BITS-1:0] cur_addr;
	logic                    finishing;
	sequencer_beat_t         expected_beats[$];
	sequencer_beat_t         request_beats[$];
	sequencer_beat_t         seen_beat;
	sequencer_beat_t         oldest_beat;

	function automatic string beat_text(input sequencer_beat_t b);
		return $sformatf("spi=%02h send=%b desel=%b rd=%02h rdv=%b done=%b end=%b",
			b.spi_out_byte, b.send_valid, b.deselect_after, b.read_value,
			b.read_valid, b.op_done, b.run_end);
	endfunction

	task add_spi(input logic [seps_pkg::BYTE_W-1:0] b, input logic desel);
		sequencer_beat_t nb;
		nb                = '0;
		nb.spi_out_byte   = b;
		nb.send_valid     = 1'b1;
		nb.deselect_after = desel;
		request_beats.push_back(nb);
	endtask

	task add_poll();
		add_spi(seps_pkg::CMD_RDSR, 1'b0);
		add_spi(seps_pkg::DUMMY, 1'b1);
	endtask

	task add_address_cmd(input logic [seps_pkg::BYTE_W-1:0] cmd);
		logic [15:0] wide;
		wide = 16'(cur_addr);
		add_spi(cmd, 1'b0);
		add_spi(wide[15:8], 1'b0);
		add_spi(wide[7:0], 1'b0);
	endtask

	task decode_request(input logic [seps_pkg::OPCODE_W-1:0] op,
		input logic [seps_pkg::START_W-1:0] addr,
		input logic [seps_pkg::BYTE_W-1:0] data, input logic fin);
		sequencer_beat_t nb;
		logic            boundary;
		request_beats.delete();
		nb = '0;
		case (seq_phase)
			ST_IDLE: begin
				if (op == seps_pkg::OP_BEGIN_WRITE) begin
					cur_addr  = addr[ADDRESS_BITS-1:0];
					finishing = 1'b0;
					add_spi(seps_pkg::CMD_WREN, 1'b1);
					add_poll();
					seq_phase = ST_LATCH_SET;
				end else if (op == seps_pkg::OP_BEGIN_READ) begin
					cur_addr  = addr[ADDRESS_BITS-1:0];
					finishing = 1'b0;
					add_address_cmd(seps_pkg::CMD_READ);
					seq_phase = ST_READ_READY;
				end
			end
			ST_LATCH_SET: begin
				if (op == seps_pkg::OP_STATUS_REPLY) begin
					if (!data[seps_pkg::SR_WEL_BIT]) begin
						add_poll();
					end else begin
						add_address_cmd(seps_pkg::CMD_WRITE);
						seq_phase = ST_WRITE_DATA;
					end
				end
			end
			ST_WRITE_DATA: begin
				if (op == seps_pkg::OP_WRITE_DATA) begin
					cur_addr = cur_addr + ADDRESS_BITS'(1);
					boundary = (int'(cur_addr) % PAGE_BYTES) == 0;
					add_spi(data, boundary | fin);
					if (boundary || fin) begin
						finishing = fin;
						add_poll();
						seq_phase = ST_WIP_CLEAR;
					end
				end
			end
			ST_WIP_CLEAR: begin
				if (op == seps_pkg::OP_STATUS_REPLY) begin
					if (data[seps_pkg::SR_WIP_BIT]) begin
						add_poll();
					end else if (finishing) begin
						add_spi(seps_pkg::CMD_WRDI, 1'b1);
						add_poll();
						seq_phase = ST_LATCH_CLEAR;
					end else begin
						add_spi(seps_pkg::CMD_WREN, 1'b1);
						add_poll();
						seq_phase = ST_LATCH_SET;
					end
				end
			end
			ST_LATCH_CLEAR: begin
				if (op == seps_pkg::OP_STATUS_REPLY) begin
					if (data[seps_pkg::SR_WEL_BIT]) begin
						add_poll();
					end else begin
						nb.op_done = 1'b1;
						request_beats.push_back(nb);
						finishing = 1'b0;
						seq_phase = ST_IDLE;
					end
				end
			end
			ST_READ_READY: begin
				if (op == seps_pkg::OP_READ_NEXT) begin
					finishing = fin;
					add_spi(seps_pkg::DUMMY, fin);
					seq_phase = ST_READ_WAIT;
				end
			end
			ST_READ_WAIT: begin
				if (op == seps_pkg::OP_READ_REPLY) begin
					nb.read_value = data;
					nb.read_valid = 1'b1;
					nb.op_done    = finishing;
					request_beats.push_back(nb);
					cur_addr = cur_addr + ADDRESS_BITS'(1);
					if (finishing) begin
						finishing = 1'b0;
						seq_phase = ST_IDLE;
					end else begin
						seq_phase = ST_READ_READY;
					end
				end
			end
			default: begin
				seq_phase = ST_IDLE;
			end
		endcase
		if (request_beats.size() > 0) begin
			request_beats[request_beats.size()-1].run_end = 1'b1;
			foreach (request_beats[i])
				expected_beats.push_back(request_beats[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_phase = ST_IDLE;
			cur_addr  = '0;
			finishing = 1'b0;
			expected_beats.delete();
			outstanding = 0;
			fail_count  = 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				seen_beat.spi_out_byte   = rsp.spi_out_byte;
				seen_beat.send_valid     = rsp.send_valid;
				seen_beat.deselect_after = rsp.deselect_after;
				seen_beat.read_value     = rsp.read_value;
				seen_beat.read_valid     = rsp.read_valid;
				seen_beat.op_done        = rsp.op_done;
				seen_beat.run_end        = rsp.run_end;
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected beat: %s", $realtime, beat_text(seen_beat));
				end else begin
					oldest_beat = expected_beats.pop_front();
					if (seen_beat !== oldest_beat) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t beat mismatch", $realtime);
							$display("  expected %s", beat_text(oldest_beat));
							$display("  actual   %s", beat_text(seen_beat));
						end
					end
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				decode_request(req.opcode, req.start_address, req.data_byte, req.final_item);
			outstanding = expected_beats.size();
		end
	end

endmodule

// ===== verif/spi_eeprom_page_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_page_sequencer_tb
// Drives well-formed page write and streamed read conversations into the
// sequencer, with stray requests mixed in, random gaps on both channels, a
// long result back-pressure stretch and a full drain pause. Checking is done
// by the attached check module; this top gives the verdict.
// ----------------------------------------------------------------------------
module spi_eeprom_page_sequencer_tb;

	localparam int PAGE_BYTES   = 64;
	localparam int ADDRESS_BITS = 14;
	localparam logic [seps_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [seps_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   requests_sent;
	bit   tx_idle_on;
	bit   rx_idle_on;
	bit   rx_hold_pending;
	bit   noise_on;

	seps_req_if req_ch ();
	seps_rsp_if rsp_ch ();

	spi_eeprom_page_sequencer #(
		.PAGE_BYTES   (PAGE_BYTES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	spi_eeprom_page_sequencer_check #(
		.PAGE_BYTES   (PAGE_BYTES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#2_000_000;
		$display("** spi_eeprom_page_sequencer: FAILED **");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_pending) begin
				rx_hold_pending = 1'b0;
				rsp_ch.ready = 1'b0;
				repeat (80) @(negedge clk);
			end
			rsp_ch.ready = !(rx_idle_on && $urandom_range(0, 99) < 12);
		end
	end

	task automatic offer(input logic [seps_pkg::OPCODE_W-1:0] op,
		input logic [seps_pkg::START_W-1:0] addr,
		input logic [seps_pkg::BYTE_W-1:0] data, input logic fin);
		int gap;
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 99) < 12) begin
			gap = $urandom_range(1, 5);
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid         = 1'b1;
		req_ch.opcode        = op;
		req_ch.start_address = addr;
		req_ch.data_byte     = data;
		req_ch.final_item    = fin;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	task automatic request(input logic [seps_pkg::OPCODE_W-1:0] op,
		input logic [seps_pkg::START_W-1:0] addr,
		input logic [seps_pkg::BYTE_W-1:0] data, input logic fin);
		logic [seps_pkg::OPCODE_W-1:0] stray;
		bit                            opening;
		opening = (op == seps_pkg::OP_BEGIN_WRITE) || (op == seps_pkg::OP_BEGIN_READ);
		// stray beat the sequencer must ignore in this phase
		if (noise_on && $urandom_range(0, 99) < 10) begin
			do stray = 3'($urandom_range(0, 7));
			while (stray == op
				|| (opening && (stray == seps_pkg::OP_BEGIN_WRITE
				|| stray == seps_pkg::OP_BEGIN_READ)));
			offer(stray, 14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		end
		offer(op, addr, data, fin);
		requests_sent++;
	endtask

	task automatic go_quiet();
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic await_status(input int bit_idx, input bit target, input bit forced);
		int                          retries;
		logic [seps_pkg::BYTE_W-1:0] sr;
		retries = forced ? 1 : ($urandom_range(0, 99) < 25 ? $urandom_range(1, 2) : 0);
		repeat (retries) begin
			sr = 8'($urandom_range(0, 255));
			sr[bit_idx] = ~target;
			request(seps_pkg::OP_STATUS_REPLY, 14'($urandom_range(0, 16383)), sr,
				1'($urandom_range(0, 1)));
		end
		sr = 8'($urandom_range(0, 255));
		sr[bit_idx] = target;
		request(seps_pkg::OP_STATUS_REPLY, 14'($urandom_range(0, 16383)), sr,
			1'($urandom_range(0, 1)));
	endtask

	task automatic run_write(input logic [seps_pkg::START_W-1:0] start, input int len,
		input bit forced);
		logic [ADDRESS_BITS-1:0]     a;
		logic [seps_pkg::BYTE_W-1:0] data;
		bit                          fin;
		bit                          boundary;
		a = start;
		request(seps_pkg::OP_BEGIN_WRITE, start, 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
		await_status(seps_pkg::SR_WEL_BIT, 1'b1, forced);
		for (int i = 0; i < len; i++) begin
			a        = a + ADDRESS_BITS'(1);
			fin      = (i == len - 1);
			boundary = (int'(a) % PAGE_BYTES) == 0;
			data     = forced ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
			request(seps_pkg::OP_WRITE_DATA, 14'($urandom_range(0, 16383)), data, fin);
			if (fin || boundary) begin
				await_status(seps_pkg::SR_WIP_BIT, 1'b0, forced);
				if (!fin)
					await_status(seps_pkg::SR_WEL_BIT, 1'b1, forced);
			end
		end
		await_status(seps_pkg::SR_WEL_BIT, 1'b0, forced);
	endtask

	task automatic run_read(input logic [seps_pkg::START_W-1:0] start, input int len,
		input bit forced);
		logic [seps_pkg::BYTE_W-1:0] data;
		request(seps_pkg::OP_BEGIN_READ, start, 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
		for (int i = 0; i < len; i++) begin
			data = forced ? (i[0] ? 8'h00 : 8'hFF) : 8'($urandom_range(0, 255));
			request(seps_pkg::OP_READ_NEXT, 14'($urandom_range(0, 16383)),
				8'($urandom_range(0, 255)), i == len - 1);
			request(seps_pkg::OP_READ_REPLY, 14'($urandom_range(0, 16383)), data,
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int                           txn;
		int                           len;
		logic [seps_pkg::START_W-1:0] start;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.opcode        = seps_pkg::OP_BEGIN_WRITE;
		req_ch.start_address = '0;
		req_ch.data_byte     = '0;
		req_ch.final_item    = 1'b0;
		tx_idle_on           = 1'b1;
		rx_idle_on           = 1'b1;
		rx_hold_pending      = 1'b0;
		noise_on             = 1'b0;
		requests_sent        = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ignored in idle, address wrap, page wrap, retried polls, data extremes
		offer(OP_SPARE_LO, 14'h3FFF, 8'hFF, 1'b1);
		offer(OP_SPARE_HI, 14'h0000, 8'h00, 1'b0);
		offer(seps_pkg::OP_READ_REPLY, 14'h1234, 8'h5A, 1'b1);
		run_write(14'h3FFE, 3, 1'b1);
		run_read(14'h3FFF, 2, 1'b1);
		run_read(14'h0000, 1, 1'b1);

		go_quiet();
		wait (outstanding == 0);

		noise_on = 1'b1;
		txn      = 0;
		while (requests_sent < 130) begin
			if (txn == 2)
				rx_hold_pending = 1'b1;
			if (txn == 4) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			if (txn == 10) begin
				tx_idle_on = 1'b1;
				rx_idle_on = 1'b1;
				go_quiet();
				wait (outstanding == 0);
			end
			start = 14'($urandom_range(0, 16383));
			if ($urandom_range(0, 99) < 30)
				start[5:0] = 6'(PAGE_BYTES - $urandom_range(1, 4));
			if ($urandom_range(0, 1)) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 70) : $urandom_range(1, 4);
				run_write(start, len, 1'b0);
			end else begin
				run_read(start, $urandom_range(1, 6), 1'b0);
			end
			txn++;
		end

		go_quiet();
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("** spi_eeprom_page_sequencer: PASSED **");
		end else begin
			$display("** spi_eeprom_page_sequencer: FAILED **");
		end
		$finish;
	end

endmodule
